FILE: rtl/core/b2g_pkg.sv
// b2g_pkg: shared types and constants for the BMP-to-gray stream block.
// Holds the channel payload structs, the parse phase enum and the error codes.
// No dependencies.
package b2g_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_HEIGHT_DEF  = 1024;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int COORD_W = 10;
    localparam int SUM_W   = 10;

    localparam logic        KIND_PIXEL = 1'b0;
    localparam logic        KIND_ERROR = 1'b1;

    localparam logic [2:0]  ERR_SIGNATURE = 3'd0;
    localparam logic [2:0]  ERR_PLANES    = 3'd1;
    localparam logic [2:0]  ERR_DEPTH     = 3'd2;
    localparam logic [2:0]  ERR_COMPRESS  = 3'd3;
    localparam logic [2:0]  ERR_SIZE      = 3'd4;
    localparam logic [2:0]  ERR_TRUNC     = 3'd5;

    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
    localparam logic [15:0] BPP_24        = 16'd24;
    localparam logic [15:0] ONE_PLANE     = 16'd1;
    localparam logic [31:0] SIG_CHECK_POS = 32'd13;
    localparam logic [31:0] HEADER_LAST   = 32'd53;
    localparam logic [31:0] PIXEL_BASE    = 32'd54;

    // (x * 683) >> 11 equals x / 3 for every x below 2046
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS
    } b2g_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       file_end;
    } b2g_in_t;

    typedef struct packed {
        logic               result_kind;
        logic [2:0]         error_code;
        logic [7:0]         gray_value;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               last_pixel;
    } b2g_out_t;

    typedef struct packed {
        logic               kind;
        logic [2:0]         code;
        logic [SUM_W-1:0]   sum;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               last;
    } b2g_work_t;

    typedef struct packed {
        logic      valid;
        b2g_work_t work;
    } b2g_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } b2g_qstat_t;

endpackage

FILE: rtl/core/bmp24_stream_to_gray.sv
// bmp24_stream_to_gray: top level of the BMP byte stream to gray pixel block.
// Instantiates b2g_front, b2g_queue and b2g_back; uses b2g_pkg.
//
//   channel   signals                              transfer carries
//   item      item_valid / item_ready / item       one file byte with start/end marks
//   result    result_valid / result_ready / result one gray pixel or one error report
//
// One byte is taken per cycle while the queue is not full (sustained while
// result_ready is high); each result passes the queue, then the output register.
// item_ready drops only while the queue is full, which happens when result_ready
// stays low. Reset returns the parser to waiting for a file start and empties
// the queue and output register; no clearing pass is needed.
module bmp24_stream_to_gray
    import b2g_pkg::*;
#(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  b2g_in_t  item,
    output logic     result_valid,
    input  logic     result_ready,
    output b2g_out_t result
);

    b2g_push_t  push;
    b2g_qstat_t qstat;
    b2g_work_t  head;
    logic       pop;

    b2g_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .qstat      (qstat),
        .push       (push)
    );

    b2g_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .qstat (qstat)
    );

    b2g_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

`ifndef ASSERT_OFF
    a_empty_truncated: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item.first_byte && item.file_end) |->
        (push.valid && (push.work.kind == KIND_ERROR) && (push.work.code == ERR_TRUNC)))
        else $error("empty file did not report truncated");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.result_kind == KIND_ERROR)) |->
        ((result.gray_value == 8'd0) && (result.column == '0) && (result.row == '0)
         && !result.last_pixel))
        else $error("error result carries pixel fields");

    a_pixel_code: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.result_kind == KIND_PIXEL)) |-> (result.error_code == 3'd0))
        else $error("pixel result carries an error code");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.full |-> !push.valid)
        else $error("queue written while full");
`endif

endmodule

FILE: rtl/core/b2g_front.sv
// b2g_front: byte parser; gathers the headers, checks them, skips to the pixels
// and turns each BGR triple or error into a queue work entry. Uses b2g_pkg.
module b2g_front
    import b2g_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  b2g_in_t    item,
    input  b2g_qstat_t qstat,
    output b2g_push_t  push
);

    localparam int COL_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 1);

    b2g_phase_t       phase_reg, phase_next;
    logic [31:0]      pos_reg, pos_next;
    logic [15:0]      sig_reg, sig_next;
    logic [31:0]      offset_reg, offset_next;
    logic [31:0]      width_reg, width_next;
    logic [31:0]      height_reg, height_next;
    logic [15:0]      planes_reg, planes_next;
    logic [15:0]      bpp_reg, bpp_next;
    logic [31:0]      comp_reg, comp_next;
    logic             flip_reg, flip_next;
    logic [ROW_W-1:0] hrows_reg, hrows_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [1:0]       chan_reg, chan_next;
    logic [1:0]       pad_reg, pad_next;
    logic [7:0]       blue_reg, blue_next;
    logic [7:0]       green_reg, green_next;

    logic             acc;
    b2g_phase_t       ph_cur;
    logic [31:0]      pos_cur;
    logic [31:0]      pos_inc;
    logic [1:0]       lane;
    logic             sig_check;
    logic             sig_bad;
    logic             hdr_last;
    logic [31:0]      height_mag;
    logic             bad_planes;
    logic             bad_bpp;
    logic             bad_comp;
    logic             bad_size;
    logic             hdr_bad;
    logic             skip_done;
    logic             pix_red;
    logic [COL_W-1:0] col_inc;
    logic [ROW_W-1:0] row_inc;
    logic             col_wrap;
    logic             is_last;
    logic [ROW_W-1:0] row_out;

    assign item_ready = !qstat.full;
    assign acc        = item_valid && item_ready;
    assign ph_cur     = item.first_byte ? PH_HEADER : phase_reg;
    assign pos_cur    = item.first_byte ? 32'd0 : pos_reg;
    assign pos_inc    = pos_cur + 32'd1;
    assign lane       = pos_cur[1:0] + 2'd2;

    assign sig_check  = (pos_cur == SIG_CHECK_POS);
    assign sig_bad    = sig_check && (sig_reg != BMP_SIGNATURE);
    assign hdr_last   = (pos_cur == HEADER_LAST);
    assign height_mag = height_reg[31] ? (~height_reg + 32'd1) : height_reg;
    assign bad_planes = (planes_reg != ONE_PLANE);
    assign bad_bpp    = (bpp_reg != BPP_24);
    assign bad_comp   = (comp_reg != 32'd0);
    assign bad_size   = (offset_reg < PIXEL_BASE) || width_reg[31] || (width_reg == 32'd0)
                        || (width_reg > 32'(MAX_WIDTH)) || (height_mag > 32'(MAX_HEIGHT));
    assign hdr_bad    = bad_planes || bad_bpp || bad_comp || bad_size;
    assign skip_done  = (pos_inc == offset_reg);

    assign pix_red    = (pad_reg == 2'd0) && chan_reg[1];
    assign col_inc    = col_reg + COL_W'(1);
    assign row_inc    = row_reg + ROW_W'(1);
    assign col_wrap   = (col_inc == width_reg[COL_W-1:0]);
    assign is_last    = (row_inc == hrows_reg) && col_wrap;
    assign row_out    = flip_reg ? (hrows_reg - ROW_W'(1) - row_reg) : row_reg;

    always_comb
    begin
        phase_next = phase_reg;
        if (acc)
        begin
            if (item.file_end)
            begin
                phase_next = PH_WAIT;
            end
            else
            begin
                case (ph_cur)
                    PH_HEADER:
                    begin
                        if (sig_bad)
                            phase_next = PH_WAIT;
                        else if (hdr_last)
                        begin
                            if (hdr_bad || (height_mag == 32'd0))
                                phase_next = PH_WAIT;
                            else if (offset_reg == PIXEL_BASE)
                                phase_next = PH_PIXELS;
                            else
                                phase_next = PH_SKIP;
                        end
                        else
                            phase_next = PH_HEADER;
                    end
                    PH_SKIP:
                        phase_next = skip_done ? PH_PIXELS : PH_SKIP;
                    PH_PIXELS:
                        phase_next = (pix_red && is_last) ? PH_WAIT : PH_PIXELS;
                    default:
                        phase_next = PH_WAIT;
                endcase
            end
        end
    end

    always_comb
    begin
        pos_next    = pos_reg;
        sig_next    = sig_reg;
        offset_next = offset_reg;
        width_next  = width_reg;
        height_next = height_reg;
        planes_next = planes_reg;
        bpp_next    = bpp_reg;
        comp_next   = comp_reg;
        flip_next   = flip_reg;
        hrows_next  = hrows_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        chan_next   = chan_reg;
        pad_next    = pad_reg;
        blue_next   = blue_reg;
        green_next  = green_reg;
        push        = '0;
        push.work.kind = KIND_ERROR;

        if (acc && item.file_end)
        begin
            if (ph_cur != PH_WAIT)
            begin
                push.valid     = 1'b1;
                push.work.code = ERR_TRUNC;
            end
        end
        else if (acc)
        begin
            case (ph_cur)
                PH_HEADER:
                begin
                    pos_next = pos_inc;
                    if (pos_cur < 32'd2)
                        sig_next[pos_cur[0]*8 +: 8] = item.data_byte;
                    else if (pos_cur >= 32'd10 && pos_cur < 32'd14)
                        offset_next[lane*8 +: 8] = item.data_byte;
                    else if (pos_cur >= 32'd18 && pos_cur < 32'd22)
                        width_next[lane*8 +: 8] = item.data_byte;
                    else if (pos_cur >= 32'd22 && pos_cur < 32'd26)
                        height_next[lane*8 +: 8] = item.data_byte;
                    else if (pos_cur >= 32'd26 && pos_cur < 32'd28)
                        planes_next[pos_cur[0]*8 +: 8] = item.data_byte;
                    else if (pos_cur >= 32'd28 && pos_cur < 32'd30)
                        bpp_next[pos_cur[0]*8 +: 8] = item.data_byte;
                    else if (pos_cur >= 32'd30 && pos_cur < 32'd34)
                        comp_next[lane*8 +: 8] = item.data_byte;

                    if (sig_bad)
                    begin
                        push.valid     = 1'b1;
                        push.work.code = ERR_SIGNATURE;
                    end
                    else if (hdr_last)
                    begin
                        if (hdr_bad)
                        begin
                            push.valid = 1'b1;
                            if (bad_planes)
                                push.work.code = ERR_PLANES;
                            else if (bad_bpp)
                                push.work.code = ERR_DEPTH;
                            else if (bad_comp)
                                push.work.code = ERR_COMPRESS;
                            else
                                push.work.code = ERR_SIZE;
                        end
                        flip_next  = !height_reg[31];
                        hrows_next = height_mag[ROW_W-1:0];
                        col_next   = '0;
                        row_next   = '0;
                        chan_next  = 2'd0;
                        pad_next   = 2'd0;
                    end
                end
                PH_SKIP:
                begin
                    pos_next = pos_inc;
                end
                PH_PIXELS:
                begin
                    if (pad_reg != 2'd0)
                        pad_next = pad_reg - 2'd1;
                    else if (chan_reg == 2'd0)
                    begin
                        blue_next = item.data_byte;
                        chan_next = 2'd1;
                    end
                    else if (chan_reg == 2'd1)
                    begin
                        green_next = item.data_byte;
                        chan_next  = 2'd2;
                    end
                    else
                    begin
                        chan_next        = 2'd0;
                        push.valid       = 1'b1;
                        push.work.kind   = KIND_PIXEL;
                        push.work.sum    = SUM_W'(blue_reg) + SUM_W'(green_reg)
                                           + SUM_W'(item.data_byte);
                        push.work.column = COORD_W'(col_reg);
                        push.work.row    = COORD_W'(row_out);
                        push.work.last   = is_last;
                        if (col_wrap)
                        begin
                            col_next = '0;
                            row_next = row_inc;
                            pad_next = width_reg[1:0];
                        end
                        else
                            col_next = col_inc;
                    end
                end
                default:
                begin
                    pos_next = pos_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT;
            pos_reg    <= '0;
            sig_reg    <= '0;
            offset_reg <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            planes_reg <= '0;
            bpp_reg    <= '0;
            comp_reg   <= '0;
            flip_reg   <= 1'b1;
            hrows_reg  <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            chan_reg   <= '0;
            pad_reg    <= '0;
            blue_reg   <= '0;
            green_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            sig_reg    <= sig_next;
            offset_reg <= offset_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            planes_reg <= planes_next;
            bpp_reg    <= bpp_next;
            comp_reg   <= comp_next;
            flip_reg   <= flip_next;
            hrows_reg  <= hrows_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            chan_reg   <= chan_next;
            pad_reg    <= pad_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
        end
    end

endmodule

FILE: rtl/core/b2g_queue.sv
// b2g_queue: short register queue of work entries between parser and output.
// Uses b2g_pkg for the entry and status types.
module b2g_queue
    import b2g_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  b2g_push_t  push,
    input  logic       pop,
    output b2g_work_t  head,
    output b2g_qstat_t qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b2g_work_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head        = slot_reg[rd_reg];
    assign qstat.full  = (count_reg == CNT_W'(DEPTH));
    assign qstat.empty = (count_reg == '0);

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push.valid)
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        if (pop)
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        if (push.valid && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push.valid)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            slot_reg[wr_reg] <= push.work;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/core/b2g_back.sv
// b2g_back: takes work entries from the queue, divides the channel sum by three
// and holds the result in the output register. Uses b2g_pkg.
module b2g_back
    import b2g_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  b2g_work_t  head,
    input  b2g_qstat_t qstat,
    output logic       pop,
    output logic       result_valid,
    input  logic       result_ready,
    output b2g_out_t   result
);

    logic        valid_reg, valid_next;
    b2g_out_t    data_reg, data_next;
    logic [19:0] product;

    assign pop     = !qstat.empty && (!valid_reg || result_ready);
    assign product = 20'(head.sum) * 20'(DIV3_MUL);

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (pop)
        begin
            valid_next             = 1'b1;
            data_next.result_kind  = head.kind;
            data_next.error_code   = head.code;
            data_next.gray_value   = (head.kind == KIND_PIXEL) ?
                                     product[DIV3_SHIFT +: 8] : 8'd0;
            data_next.column       = head.column;
            data_next.row          = head.row;
            data_next.last_pixel   = head.last;
        end
        else if (result_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule
